/* rtl/mmls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mmls_pkg;

   localparam int MAX_SIDE = 64;
   localparam int SIDE_W   = 7;
   localparam int POS_W    = $clog2(MAX_SIDE);
   localparam int ELEM_W   = 16;
   localparam int ACC_W    = 22;
   localparam int RES_W    = 21;

   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(4);

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [RES_W-1:0]         result_type;
   typedef logic [SIDE_W-1:0]        side_type;
   typedef logic [POS_W-1:0]         pos_idx_type;

   typedef struct packed {
      logic        first_row;
      logic        last_row;
      logic        last_col;
      logic        on_main;
      logic        on_anti;
      pos_idx_type column;
   } pos_type;

endpackage

`default_nettype wire

/* rtl/mmls_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mmls_req_if import mmls_pkg::*; ();
   logic     valid;
   logic     ready;
   elem_type element_value;

   modport source (output valid, output element_value, input ready);
   modport sink   (input valid, input element_value, output ready);
endinterface

interface mmls_rsp_if import mmls_pkg::*; ();
   logic       valid;
   logic       ready;
   result_type max_line_sum;

   modport source (output valid, output max_line_sum, input ready);
   modport sink   (input valid, input max_line_sum, output ready);
endinterface

interface mmls_csr_if import mmls_pkg::*; ();
   logic     valid;
   logic     ready;
   side_type side_length;

   modport source (output valid, output side_length, input ready);
   modport sink   (input valid, input side_length, output ready);
endinterface

`default_nettype wire

/* rtl/mmls_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module mmls_seq import mmls_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_write,
   input  side_type csr_side,
   input  logic     advance,
   output pos_type  pos
);

   side_type    side_ff, side_in;
   pos_idx_type row_ff, row_in;
   pos_idx_type col_ff, col_in;
   side_type    side_eff;
   pos_idx_type last_idx;

   always_comb begin
      if (side_ff == '0) begin
         side_eff = SIDE_W'(1);
      end else if (side_ff > SIDE_W'(MAX_SIDE)) begin
         side_eff = SIDE_W'(MAX_SIDE);
      end else begin
         side_eff = side_ff;
      end
      last_idx = POS_W'(side_eff - SIDE_W'(1));
   end

   always_comb begin
      pos.first_row = (row_ff == '0);
      pos.last_row  = (row_ff == last_idx);
      pos.last_col  = (col_ff == last_idx);
      pos.on_main   = (row_ff == col_ff);
      pos.on_anti   = ((POS_W+1)'(row_ff) + (POS_W+1)'(col_ff)) == (POS_W+1)'(last_idx);
      pos.column    = col_ff;
   end

   always_comb begin
      side_in = side_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (csr_write) begin
         side_in = csr_side;
         row_in  = '0;
         col_in  = '0;
      end else if (advance) begin
         if (pos.last_col) begin
            col_in = '0;
            row_in = pos.last_row ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_RESET;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         side_ff <= side_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= last_idx) && (col_ff <= last_idx))
      else $error("position beyond side length");

   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && pos.last_row && pos.last_col) |=> (row_ff == '0) && (col_ff == '0))
      else $error("position did not wrap after last element");

endmodule

`default_nettype wire

/* rtl/mmls_accum.sv */
`timescale 1ns / 1ps
`default_nettype none

module mmls_accum import mmls_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  logic        rd_en,
   input  pos_idx_type rd_addr,
   input  logic        fire,
   input  elem_type    element,
   input  pos_type     pos,
   output result_type  result
);

   acc_type    col_mem [MAX_SIDE];
   acc_type    col_rd_ff;

   acc_type    row_acc_ff, row_acc_in;
   acc_type    main_ff, main_in;
   acc_type    anti_ff, anti_in;
   result_type best_row_ff, best_row_in;
   result_type best_col_ff, best_col_in;

   acc_type    value;
   acc_type    col_sum;
   acc_type    row_sum;
   acc_type    main_sum;
   acc_type    anti_sum;
   result_type best_row_new;
   result_type best_col_new;
   acc_type    best;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         col_rd_ff <= col_mem[rd_addr];
      end
      if (fire) begin
         col_mem[pos.column] <= col_sum;
      end
   end

   always_comb begin
      value    = acc_type'(element);
      col_sum  = pos.first_row ? value : col_rd_ff + value;
      row_sum  = row_acc_ff + value;
      main_sum = pos.on_main ? main_ff + value : main_ff;
      anti_sum = pos.on_anti ? anti_ff + value : anti_ff;

      best_row_new = best_row_ff;
      if (pos.last_col && (row_sum > $signed({1'b0, best_row_ff}))) begin
         best_row_new = row_sum[RES_W-1:0];
      end
      best_col_new = best_col_ff;
      if (pos.last_row && (col_sum > $signed({1'b0, best_col_ff}))) begin
         best_col_new = col_sum[RES_W-1:0];
      end

      best = $signed({1'b0, best_row_new});
      if ($signed({1'b0, best_col_new}) > best) begin
         best = $signed({1'b0, best_col_new});
      end
      if (main_sum > best) begin
         best = main_sum;
      end
      if (anti_sum > best) begin
         best = anti_sum;
      end
      result = best[RES_W-1:0];
   end

   always_comb begin
      row_acc_in  = row_acc_ff;
      main_in     = main_ff;
      anti_in     = anti_ff;
      best_row_in = best_row_ff;
      best_col_in = best_col_ff;
      if (clear || (fire && pos.last_row && pos.last_col)) begin
         row_acc_in  = '0;
         main_in     = '0;
         anti_in     = '0;
         best_row_in = '0;
         best_col_in = '0;
      end else if (fire) begin
         row_acc_in  = pos.last_col ? '0 : row_sum;
         main_in     = main_sum;
         anti_in     = anti_sum;
         best_row_in = best_row_new;
         best_col_in = best_col_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_acc_ff  <= '0;
         main_ff     <= '0;
         anti_ff     <= '0;
         best_row_ff <= '0;
         best_col_ff <= '0;
      end else begin
         row_acc_ff  <= row_acc_in;
         main_ff     <= main_in;
         anti_ff     <= anti_in;
         best_row_ff <= best_row_in;
         best_col_ff <= best_col_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/matrix_max_line_sum_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Streams the elements of a square matrix in row-major order, one transaction per element,
// with the side length (1 to 64; 0 reads as 1, larger values as 64) written on the csr
// channel, which also restarts the matrix in progress. On the last element one rsp
// transaction carries the largest of the best row sum, best column sum and both diagonal
// sums, floored at zero; all other elements give none. One element per clock is sustained
// unless rsp stalls: each element passes an input register, then adders and compares into
// the running sums and output register. Column sums live in a 64-entry memory read as the
// element enters the input register and written as it leaves. No clearing pass is needed.

module matrix_max_line_sum_unit import mmls_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mmls_req_if.sink   req_chan,
   mmls_rsp_if.source rsp_chan,
   mmls_csr_if.sink   csr_chan
);

   logic       accept;
   logic       fire;
   logic       s0_last;
   logic       csr_write;
   pos_type    pos;
   result_type result;

   logic       s0_valid_ff, s0_valid_in;
   elem_type   s0_elem_ff;
   pos_type    s0_pos_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   assign s0_last        = s0_pos_ff.last_row && s0_pos_ff.last_col;
   assign fire           = s0_valid_ff && (!s0_last || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s0_valid_ff || fire;
   assign accept         = req_chan.valid && req_chan.ready;

   mmls_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_side  (csr_chan.side_length),
      .advance   (accept),
      .pos       (pos)
   );

   mmls_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_write),
      .rd_en   (accept),
      .rd_addr (pos.column),
      .fire    (fire),
      .element (s0_elem_ff),
      .pos     (s0_pos_ff),
      .result  (result)
   );

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (accept) begin
         s0_valid_in = 1'b1;
      end else if (fire) begin
         s0_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire && s0_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_elem_ff <= req_chan.element_value;
         s0_pos_ff  <= pos;
      end
      if (fire && s0_last) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.max_line_sum = rsp_data_ff;

   a_result_after_last: assert property (@(posedge clock) disable iff (reset)
      (fire && s0_last) |=> rsp_valid_ff)
      else $error("last element did not produce a result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire && s0_last))
      else $error("result raised without a last element");

endmodule

`default_nettype wire

/* test/matrix_max_line_sum_checker.sv */
`timescale 1ns / 1ps

module matrix_max_line_sum_checker import mmls_pkg::*; (
   input  logic clock,
   input  logic reset,
   mmls_req_if  req_chan,
   mmls_rsp_if  rsp_chan,
   mmls_csr_if  csr_chan,
   output int   mismatch_count,
   output int   pending_sums
);

   side_type    side_setting;
   pos_idx_type row_pos;
   pos_idx_type col_pos;
   acc_type     row_run;
   acc_type     best_row;
   acc_type     main_diag;
   acc_type     anti_diag;
   acc_type     best_col;
   acc_type     col_run [MAX_SIDE];
   result_type  expected_sums [$];
   int          failures = 0;

   function automatic void restart_matrix();
      row_pos   = '0;
      col_pos   = '0;
      row_run   = '0;
      best_row  = '0;
      main_diag = '0;
      anti_diag = '0;
      best_col  = '0;
   endfunction

   function automatic void absorb_element(input elem_type value);
      int      n;
      int      r;
      int      c;
      acc_type best;
      if (side_setting == 0)
         n = 1;
      else if (side_setting > MAX_SIDE)
         n = MAX_SIDE;
      else
         n = side_setting;
      r = row_pos;
      c = col_pos;
      if (c >= n) c = n - 1;
      if (r >= n) r = n - 1;

      row_run = row_run + value;
      if (r == 0)
         col_run[c] = value;
      else
         col_run[c] = col_run[c] + value;
      if (r == c) main_diag = main_diag + value;
      if (r + c == n - 1) anti_diag = anti_diag + value;

      if (r == n - 1 && col_run[c] > best_col) best_col = col_run[c];

      if (c == n - 1) begin
         if (row_run > best_row) best_row = row_run;
         row_run = '0;
      end

      if (r == n - 1 && c == n - 1) begin
         best = best_row;
         if (best_col > best) best = best_col;
         if (main_diag > best) best = main_diag;
         if (anti_diag > best) best = anti_diag;
         expected_sums.push_back(result_type'(best));
         restart_matrix();
      end else if (c == n - 1) begin
         col_pos = '0;
         row_pos = pos_idx_type'(r + 1);
      end else begin
         col_pos = pos_idx_type'(c + 1);
         row_pos = pos_idx_type'(r);
      end
   endfunction

   always @(posedge clock) begin : watch
      result_type wanted;
      if (reset) begin
         side_setting = SIDE_RESET;
         restart_matrix();
         expected_sums.delete();
      end else begin
         // a result cannot belong to an element taken at the same edge
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_sums.size() == 0) begin
               $error("max_line_sum: no result expected, actual %0d", rsp_chan.max_line_sum);
               failures++;
            end else begin
               wanted = expected_sums.pop_front();
               if (rsp_chan.max_line_sum !== wanted) begin
                  $error("max_line_sum mismatch: expected %0d, actual %0d",
                         wanted, rsp_chan.max_line_sum);
                  failures++;
               end
            end
         end
         if (csr_chan.valid && csr_chan.ready) begin
            side_setting = csr_chan.side_length;
            restart_matrix();
         end
         if (req_chan.valid && req_chan.ready) absorb_element(req_chan.element_value);
      end
      mismatch_count <= failures;
      pending_sums   <= expected_sums.size();
   end

endmodule

/* test/matrix_max_line_sum_unit_tb.sv */
`timescale 1ns / 1ps

module matrix_max_line_sum_unit_tb import mmls_pkg::*; ();

   localparam int QUIET_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 360;
   localparam int SETTLE_CYCLES = 8;

   typedef enum int {
      FILL_RANDOM,
      FILL_MAX,
      FILL_MIN,
      FILL_SMALL_POS,
      FILL_SMALL_MIX,
      FILL_EXTREMES
   } fill_kind_type;

   logic clock;
   logic reset;
   int   send_gap_pct  = 0;
   int   rsp_stall_pct = 0;
   int   quiet_cycles  = 0;
   int   mismatch_count;
   int   pending_sums;

   mmls_req_if req_chan ();
   mmls_rsp_if rsp_chan ();
   mmls_csr_if csr_chan ();

   matrix_max_line_sum_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   matrix_max_line_sum_checker sum_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .mismatch_count (mismatch_count),
      .pending_sums   (pending_sums)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic elem_type pick_element(input fill_kind_type kind);
      case (kind)
         FILL_MAX:       return elem_type'(32767);
         FILL_MIN:       return elem_type'(-32768);
         FILL_SMALL_POS: return elem_type'($urandom_range(0, 255));
         FILL_SMALL_MIX: return elem_type'(int'($urandom_range(0, 510)) - 255);
         FILL_EXTREMES:  return $urandom_range(0, 1) ? elem_type'(32767) : elem_type'(-32768);
         default:        return elem_type'($urandom);
      endcase
   endfunction

   function automatic fill_kind_type random_fill();
      case ($urandom_range(0, 9))
         5:       return FILL_MAX;
         6:       return FILL_MIN;
         7:       return FILL_SMALL_POS;
         8:       return FILL_SMALL_MIX;
         9:       return FILL_EXTREMES;
         default: return FILL_RANDOM;
      endcase
   endfunction

   task automatic send_element(input elem_type value);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.element_value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_matrix(input int count, input fill_kind_type kind);
      for (int i = 0; i < count; i++) send_element(pick_element(kind));
   endtask

   // holds off until every expected sum is out and the pipeline has drained
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_sums != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_side(input side_type side);
      settle();
      csr_chan.valid       <= 1'b1;
      csr_chan.side_length <= side;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic run_phase(input int budget);
      int done;
      int pick;
      int side;
      int span;
      int cut;
      done = 0;
      while (done < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 4)
            side = 0;
         else if (pick < 70)
            side = $urandom_range(1, 4);
         else if (pick < 92)
            side = $urandom_range(5, 8);
         else
            side = $urandom_range(9, 16);
         write_side(side_type'(side));
         span = (side == 0) ? 1 : side * side;
         repeat ($urandom_range(1, 3)) begin
            send_matrix(span, random_fill());
            done += span;
         end
         // partial matrix, dropped by the next register write
         if (span > 1 && $urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, span - 1);
            send_matrix(cut, random_fill());
            done += cut;
         end
      end
   endtask

   initial begin : stimulus
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.element_value = '0;
      csr_chan.valid         = 1'b0;
      csr_chan.side_length   = '0;
      rsp_chan.ready         = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_matrix(16, FILL_RANDOM);
      write_side(side_type'(1));
      send_element(elem_type'(32767));
      send_element(elem_type'(-32768));
      send_element(elem_type'(0));
      write_side(side_type'(0));
      send_element(elem_type'(12345));
      send_element(elem_type'(-1));
      write_side(side_type'(2));
      send_matrix(3, FILL_RANDOM);
      write_side(side_type'(2));
      send_element(elem_type'(-32768));
      send_element(elem_type'(32767));
      send_element(elem_type'(32767));
      send_element(elem_type'(-32768));

      // saturated side, dropped partway by the next register write
      write_side(side_type'(127));
      send_matrix(2 * MAX_SIDE + 5, FILL_MAX);
      write_side(side_type'(MAX_SIDE));
      send_matrix(200, FILL_RANDOM);

      run_phase(PHASE_ITEMS);
      send_gap_pct  = 86;
      rsp_stall_pct = 0;
      run_phase(PHASE_ITEMS);
      send_gap_pct  = 0;
      rsp_stall_pct = 86;
      run_phase(PHASE_ITEMS);
      send_gap_pct  = 9;
      rsp_stall_pct = 9;
      run_phase(PHASE_ITEMS);

      settle();
      if (mismatch_count == 0 && pending_sums == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
